@@ rtl/core/rpa_pkg.sv @@
// Shared types and constants for the reference-counted page allocator.
// No dependencies; rpa_alu and the top level refer to this package.
package rpa_pkg;

    // Width of the shared add/subtract unit: 32-bit addresses plus a borrow bit
    localparam int ALU_W = 33;

    // Operation codes carried by an input item
    typedef enum logic [2:0] {
        MODE_INIT  = 3'd0,
        MODE_ALLOC = 3'd1,
        MODE_FREE  = 3'd2,
        MODE_INC   = 3'd3,
        MODE_GET   = 3'd4,
        MODE_SET   = 3'd5
    } mode_t;

    // Result status codes
    typedef enum logic [1:0] {
        STS_OK           = 2'd0,
        STS_OUT_OF_MEM   = 2'd1,
        STS_BAD_ADDR     = 2'd2,
        STS_ALREADY_FREE = 2'd3
    } status_t;

    // Configuration register indexes
    typedef logic [1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_MEM_BASE   = 2'd0;
    localparam cfg_idx_t CFG_FIRST_FREE = 2'd1;
    localparam cfg_idx_t CFG_MEM_TOP    = 2'd2;

    // Configuration reset values
    localparam logic [31:0] MEM_BASE_RST   = 32'h8000_0000;
    localparam logic [31:0] FIRST_FREE_RST = 32'h8002_0000;
    localparam logic [31:0] MEM_TOP_RST    = 32'h8800_0000;

    // Sequencer states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_INIT_RND,
        S_INIT_START,
        S_INIT_LIMIT,
        S_INIT_SWEEP,
        S_ALLOC_RD,
        S_ALLOC_WR,
        S_CHK_BASE,
        S_CHK_TOP,
        S_CHK_FIRST,
        S_CNT_RD,
        S_CNT_WR,
        S_DONE
    } state_t;

    // Shared arithmetic unit
    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        alu_op_t          op;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } alu_req_t;

endpackage

@@ rtl/core/rpa_in_if.sv @@
// Request channel of the page allocator: valid/ready plus one request item.
// Depends on nothing.
interface rpa_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [31:0] page_address;
    logic [15:0] new_count;

    modport source (output valid, mode, page_address, new_count, input ready);
    modport sink   (input valid, mode, page_address, new_count, output ready);
endinterface

@@ rtl/core/rpa_out_if.sv @@
// Response channel of the page allocator: valid/ready plus one result item.
// Depends on nothing.
interface rpa_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] alloc_address;
    logic [15:0] ref_count;
    logic        page_released;
    logic [31:0] free_bytes;

    modport source (output valid, status, alloc_address, ref_count, page_released,
                    free_bytes, input ready);
    modport sink   (input valid, status, alloc_address, ref_count, page_released,
                    free_bytes, output ready);
endinterface

@@ rtl/core/rpa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module rpa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32768
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/rpa_alu.sv @@
// Shared 33-bit add/subtract unit; bit 32 of a subtraction is the borrow.
// Depends on rpa_pkg.
module rpa_alu (
    input  rpa_pkg::alu_req_t         req,
    output logic [rpa_pkg::ALU_W-1:0] y
);

    always_comb
    begin
        case (req.op)
            rpa_pkg::ALU_ADD: y = req.a + req.b;
            rpa_pkg::ALU_SUB: y = req.a - req.b;
            default:          y = req.a - req.b;
        endcase
    end

endmodule

@@ rtl/core/refcounted_page_allocator_top.sv @@
// Top level of the reference-counted page allocator: sequencer, count table,
// free stack and shared adder. Depends on rpa_pkg, rpa_in_if, rpa_out_if,
// rpa_ram and rpa_alu.
//
//  channel  | dir | handshake           | payload
//  ---------+-----+---------------------+------------------------------------------
//  req      | in  | valid/ready         | mode, page_address, new_count
//  rsp      | out | valid/ready         | status, alloc_address, ref_count,
//           |     |                     | page_released, free_bytes
//  cfg      | in  | cfg_write strobe    | cfg_index, cfg_data
//
//  One item at a time; req.ready is high only in the idle state.
//  Init sweeps the count table, one count-table entry per cycle through the sweep.
//  The shared adder does every address check in turn, one per cycle.
//  After reset the count table is cleared; no item is taken then.
//  The result sits in an output register, so a stalled rsp does not stop the next item
//  until that one's result is due.
module refcounted_page_allocator_top #(
    parameter int NUM_PAGES   = 32768,
    parameter int PAGE_SHIFT  = 12,
    parameter int COUNT_WIDTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    rpa_in_if.sink            req,
    rpa_out_if.source         rsp,
    input  logic              cfg_write,
    input  rpa_pkg::cfg_idx_t cfg_index,
    input  logic [31:0]       cfg_data
);

    localparam int IDX_W = $clog2(NUM_PAGES);
    localparam int TOP_W = IDX_W + 1;
    localparam int AW    = rpa_pkg::ALU_W;

    localparam logic [AW-1:0]          PAGE_MASK   = AW'((64'd1 << PAGE_SHIFT) - 64'd1);
    localparam logic [AW-1:0]          NUM_PAGES_W = AW'(NUM_PAGES);
    localparam logic [TOP_W-1:0]       NUM_PAGES_T = TOP_W'(NUM_PAGES);
    localparam logic [IDX_W-1:0]       LAST_IDX    = IDX_W'(NUM_PAGES - 1);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX   = {COUNT_WIDTH{1'b1}};
    localparam logic [COUNT_WIDTH-1:0] COUNT_ONE   = COUNT_WIDTH'(1);

    // Control registers
    rpa_pkg::state_t  state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic [TOP_W-1:0] free_top_reg, free_top_next;
    logic             out_valid_reg, out_valid_next;
    logic [31:0]      mem_base_reg, first_free_reg, mem_top_reg;

    // Working registers
    rpa_pkg::mode_t   mode_reg, mode_next;
    logic [31:0]      addr_reg, addr_next;
    logic [15:0]      newc_reg, newc_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [TOP_W-1:0] start_c_reg, start_c_next;
    logic [TOP_W-1:0] limit_c_reg, limit_c_next;
    logic [AW-1:0]    rnd_reg, rnd_next;

    // Result being built, and the output register
    rpa_pkg::status_t res_status_reg, res_status_next;
    logic [31:0]      res_alloc_reg, res_alloc_next;
    logic [15:0]      res_count_reg, res_count_next;
    logic             res_rel_reg, res_rel_next;
    rpa_pkg::status_t out_status_reg, out_status_next;
    logic [31:0]      out_alloc_reg, out_alloc_next;
    logic [15:0]      out_count_reg, out_count_next;
    logic             out_rel_reg, out_rel_next;
    logic [31:0]      out_bytes_reg, out_bytes_next;

    // Memory ports
    logic                   ref_we, stk_we;
    logic [IDX_W-1:0]       ref_waddr, stk_waddr, ref_raddr, stk_raddr;
    logic [COUNT_WIDTH-1:0] ref_wdata, ref_rdata;
    logic [IDX_W-1:0]       stk_wdata, stk_rdata;

    // Shared adder
    rpa_pkg::alu_req_t alu_req;
    logic [AW-1:0]     alu_y;

    // Derived values
    logic [31:0]            base_al;
    logic                   alu_borrow;
    logic [AW-1:0]          alu_shr;
    logic [TOP_W-1:0]       clamp_idx;
    logic [TOP_W-1:0]       cnt_ext;
    logic                   in_range;
    logic [63:0]            bytes_wide;
    logic [31:0]            free_bytes;
    logic [COUNT_WIDTH-1:0] cnt_new;

    rpa_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(NUM_PAGES)) u_ref_ram (
        .clk   (clk),
        .we    (ref_we),
        .waddr (ref_waddr),
        .wdata (ref_wdata),
        .raddr (ref_raddr),
        .rdata (ref_rdata)
    );

    rpa_ram #(.WIDTH(IDX_W), .DEPTH(NUM_PAGES)) u_stk_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    rpa_alu u_alu (
        .req (alu_req),
        .y   (alu_y)
    );

    // Fixed read addresses: stack top for alloc, checked page for counts
    assign stk_raddr = IDX_W'(free_top_reg - TOP_W'(1));
    assign ref_raddr = idx_reg;

    assign base_al   = mem_base_reg & ~PAGE_MASK[31:0];
    // Top bit is a borrow only when the minuend did not already carry it
    // (a rounded-up start address can reach 2^32)
    assign alu_borrow = alu_y[AW-1] & ~alu_req.a[AW-1];
    assign alu_shr   = alu_y >> PAGE_SHIFT;
    assign clamp_idx = alu_borrow ? '0 :
                       (alu_shr > NUM_PAGES_W) ? NUM_PAGES_T : alu_shr[TOP_W-1:0];
    assign cnt_ext   = {1'b0, cnt_reg};
    assign in_range  = (cnt_ext >= start_c_reg) && (cnt_ext < limit_c_reg);

    // Free byte total, saturated to 32 bits
    assign bytes_wide = 64'(free_top_reg) << PAGE_SHIFT;
    assign free_bytes = (|bytes_wide[63:32]) ? 32'hFFFF_FFFF : bytes_wide[31:0];

    assign cnt_new = alu_y[COUNT_WIDTH-1:0];

    assign req.ready         = (state_reg == rpa_pkg::S_IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.alloc_address = out_alloc_reg;
    assign rsp.ref_count     = out_count_reg;
    assign rsp.page_released = out_rel_reg;
    assign rsp.free_bytes    = out_bytes_reg;

    // Sequencer: next state, working registers and memory/adder controls
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        free_top_next   = free_top_reg;
        out_valid_next  = out_valid_reg;
        mode_next       = mode_reg;
        addr_next       = addr_reg;
        newc_next       = newc_reg;
        idx_next        = idx_reg;
        start_c_next    = start_c_reg;
        limit_c_next    = limit_c_reg;
        rnd_next        = rnd_reg;
        res_status_next = res_status_reg;
        res_alloc_next  = res_alloc_reg;
        res_count_next  = res_count_reg;
        res_rel_next    = res_rel_reg;
        out_status_next = out_status_reg;
        out_alloc_next  = out_alloc_reg;
        out_count_next  = out_count_reg;
        out_rel_next    = out_rel_reg;
        out_bytes_next  = out_bytes_reg;
        ref_we          = 1'b0;
        ref_waddr       = idx_reg;
        ref_wdata       = '0;
        stk_we          = 1'b0;
        stk_waddr       = free_top_reg[IDX_W-1:0];
        stk_wdata       = idx_reg;
        alu_req.op      = rpa_pkg::ALU_SUB;
        alu_req.a       = {1'b0, addr_reg};
        alu_req.b       = {1'b0, base_al};

        // Result taken by the sink
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            rpa_pkg::S_CLEAR:
            begin
                ref_we    = 1'b1;
                ref_waddr = cnt_reg;
                cnt_next  = cnt_reg + IDX_W'(1);
                if (cnt_reg == LAST_IDX)
                begin
                    cnt_next   = '0;
                    state_next = rpa_pkg::S_IDLE;
                end
            end

            rpa_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    mode_next       = rpa_pkg::mode_t'(req.mode);
                    addr_next       = req.page_address;
                    newc_next       = req.new_count;
                    res_status_next = rpa_pkg::STS_OK;
                    res_alloc_next  = '0;
                    res_count_next  = '0;
                    res_rel_next    = 1'b0;
                    case (rpa_pkg::mode_t'(req.mode))
                        rpa_pkg::MODE_INIT:
                        begin
                            state_next = rpa_pkg::S_INIT_RND;
                        end
                        rpa_pkg::MODE_ALLOC:
                        begin
                            if (free_top_reg == '0)
                            begin
                                res_status_next = rpa_pkg::STS_OUT_OF_MEM;
                                state_next      = rpa_pkg::S_DONE;
                            end
                            else
                            begin
                                state_next = rpa_pkg::S_ALLOC_RD;
                            end
                        end
                        rpa_pkg::MODE_FREE, rpa_pkg::MODE_INC,
                        rpa_pkg::MODE_GET, rpa_pkg::MODE_SET:
                        begin
                            state_next = rpa_pkg::S_CHK_BASE;
                        end
                        default:
                        begin
                            state_next = rpa_pkg::S_DONE;
                        end
                    endcase
                end
            end

            // Round the first free address up to a page boundary
            rpa_pkg::S_INIT_RND:
            begin
                alu_req.op    = rpa_pkg::ALU_ADD;
                alu_req.a     = {1'b0, first_free_reg};
                alu_req.b     = PAGE_MASK;
                rnd_next      = alu_y & ~PAGE_MASK;
                free_top_next = '0;
                state_next    = rpa_pkg::S_INIT_START;
            end

            // First page index to push
            rpa_pkg::S_INIT_START:
            begin
                alu_req.a    = rnd_reg;
                start_c_next = clamp_idx;
                state_next   = rpa_pkg::S_INIT_LIMIT;
            end

            // Number of whole pages below mem_top
            rpa_pkg::S_INIT_LIMIT:
            begin
                alu_req.a    = {1'b0, mem_top_reg};
                limit_c_next = clamp_idx;
                cnt_next     = '0;
                state_next   = rpa_pkg::S_INIT_SWEEP;
            end

            // Clear each count, push the usable pages in ascending order
            rpa_pkg::S_INIT_SWEEP:
            begin
                ref_we    = 1'b1;
                ref_waddr = cnt_reg;
                stk_wdata = cnt_reg;
                if (in_range)
                begin
                    stk_we        = 1'b1;
                    free_top_next = free_top_reg + TOP_W'(1);
                end
                cnt_next = cnt_reg + IDX_W'(1);
                if (cnt_reg == LAST_IDX)
                begin
                    cnt_next   = '0;
                    state_next = rpa_pkg::S_DONE;
                end
            end

            // Stack top read in flight
            rpa_pkg::S_ALLOC_RD:
            begin
                state_next = rpa_pkg::S_ALLOC_WR;
            end

            // Pop: count to one, address = base + index * page size
            rpa_pkg::S_ALLOC_WR:
            begin
                alu_req.op     = rpa_pkg::ALU_ADD;
                alu_req.a      = {1'b0, base_al};
                alu_req.b      = AW'(stk_rdata) << PAGE_SHIFT;
                ref_we         = 1'b1;
                ref_waddr      = stk_rdata;
                ref_wdata      = COUNT_ONE;
                free_top_next  = free_top_reg - TOP_W'(1);
                res_alloc_next = alu_y[31:0];
                res_count_next = 16'(COUNT_ONE);
                state_next     = rpa_pkg::S_DONE;
            end

            // Alignment, lower bound and index range
            rpa_pkg::S_CHK_BASE:
            begin
                idx_next = alu_shr[IDX_W-1:0];
                if (alu_y[AW-1] || (addr_reg[PAGE_SHIFT-1:0] != '0) ||
                    (alu_shr >= NUM_PAGES_W))
                begin
                    res_status_next = rpa_pkg::STS_BAD_ADDR;
                    state_next      = rpa_pkg::S_DONE;
                end
                else
                begin
                    state_next = rpa_pkg::S_CHK_TOP;
                end
            end

            // Below mem_top: borrow must be set
            rpa_pkg::S_CHK_TOP:
            begin
                alu_req.b = {1'b0, mem_top_reg};
                if (!alu_y[AW-1])
                begin
                    res_status_next = rpa_pkg::STS_BAD_ADDR;
                    state_next      = rpa_pkg::S_DONE;
                end
                else if (mode_reg == rpa_pkg::MODE_FREE)
                begin
                    state_next = rpa_pkg::S_CHK_FIRST;
                end
                else
                begin
                    state_next = rpa_pkg::S_CNT_RD;
                end
            end

            // Free only: not below the first free address
            rpa_pkg::S_CHK_FIRST:
            begin
                alu_req.b = {1'b0, first_free_reg};
                if (alu_y[AW-1])
                begin
                    res_status_next = rpa_pkg::STS_BAD_ADDR;
                    state_next      = rpa_pkg::S_DONE;
                end
                else
                begin
                    state_next = rpa_pkg::S_CNT_RD;
                end
            end

            // Count read in flight
            rpa_pkg::S_CNT_RD:
            begin
                state_next = rpa_pkg::S_CNT_WR;
            end

            // Count update, or a plain read for get
            rpa_pkg::S_CNT_WR:
            begin
                alu_req.op = (mode_reg == rpa_pkg::MODE_INC) ? rpa_pkg::ALU_ADD
                                                             : rpa_pkg::ALU_SUB;
                alu_req.a  = AW'(ref_rdata);
                alu_req.b  = AW'(1);
                state_next = rpa_pkg::S_DONE;
                case (mode_reg)
                    rpa_pkg::MODE_FREE:
                    begin
                        if (ref_rdata == '0)
                        begin
                            res_status_next = rpa_pkg::STS_ALREADY_FREE;
                        end
                        else
                        begin
                            ref_we         = 1'b1;
                            ref_wdata      = cnt_new;
                            res_count_next = 16'(cnt_new);
                            if ((cnt_new == '0) && (free_top_reg < NUM_PAGES_T))
                            begin
                                stk_we        = 1'b1;
                                free_top_next = free_top_reg + TOP_W'(1);
                                res_rel_next  = 1'b1;
                            end
                        end
                    end
                    rpa_pkg::MODE_INC:
                    begin
                        ref_we         = 1'b1;
                        ref_wdata      = (ref_rdata == COUNT_MAX) ? ref_rdata : cnt_new;
                        res_count_next = 16'(ref_wdata);
                    end
                    rpa_pkg::MODE_SET:
                    begin
                        ref_we         = 1'b1;
                        ref_wdata      = COUNT_WIDTH'(newc_reg);
                        res_count_next = 16'(ref_wdata);
                    end
                    default:
                    begin
                        res_count_next = 16'(ref_rdata);
                    end
                endcase
            end

            // Hand the result to the output register once it is free
            rpa_pkg::S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_alloc_next  = res_alloc_reg;
                    out_count_next  = res_count_reg;
                    out_rel_next    = res_rel_reg;
                    out_bytes_next  = free_bytes;
                    state_next      = rpa_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = rpa_pkg::S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rpa_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            free_top_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            free_top_reg  <= free_top_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_base_reg   <= rpa_pkg::MEM_BASE_RST;
            first_free_reg <= rpa_pkg::FIRST_FREE_RST;
            mem_top_reg    <= rpa_pkg::MEM_TOP_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                rpa_pkg::CFG_MEM_BASE:   mem_base_reg   <= cfg_data;
                rpa_pkg::CFG_FIRST_FREE: first_free_reg <= cfg_data;
                rpa_pkg::CFG_MEM_TOP:    mem_top_reg    <= cfg_data;
                default:                 ;
            endcase
        end
    end

    // Working and result payload registers
    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        addr_reg       <= addr_next;
        newc_reg       <= newc_next;
        idx_reg        <= idx_next;
        start_c_reg    <= start_c_next;
        limit_c_reg    <= limit_c_next;
        rnd_reg        <= rnd_next;
        res_status_reg <= res_status_next;
        res_alloc_reg  <= res_alloc_next;
        res_count_reg  <= res_count_next;
        res_rel_reg    <= res_rel_next;
        out_status_reg <= out_status_next;
        out_alloc_reg  <= out_alloc_next;
        out_count_reg  <= out_count_next;
        out_rel_reg    <= out_rel_next;
        out_bytes_reg  <= out_bytes_next;
    end

`ifndef SYNTHESIS
    // Free count never exceeds the number of pages
    a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_top_reg <= NUM_PAGES_T)
        else $error("free stack count above page total");

    // A release pushes only a page whose count has just reached zero
    a_push_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rpa_pkg::S_CNT_WR && stk_we) |-> (ref_we && ref_wdata == '0))
        else $error("page pushed with a nonzero count");

    // Alloc pops only from a non-empty stack
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rpa_pkg::S_ALLOC_WR) |-> (free_top_reg != '0))
        else $error("pop from empty free stack");

    // No memory write while waiting for an item
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rpa_pkg::S_IDLE) |-> (!ref_we && !stk_we))
        else $error("memory written while idle");
`endif

endmodule
